// ===== hdl/i2c_thermometer_scan_and_read_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thermometer poller core
// Short forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef I2C_THERMOMETER_SCAN_AND_READ_CORE_ASSERT_SVH
`define I2C_THERMOMETER_SCAN_AND_READ_CORE_ASSERT_SVH

// Same-cycle implication, checked on aclk while out of reset.
`define TSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("thermometer poller check failed");

// Next-cycle implication, checked on aclk while out of reset.
`define TSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("thermometer poller check failed");

`endif

// ===== hdl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsr_pkg
// Types, codes and reset constants of the thermometer poller core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsr_pkg;

    localparam int NUM_SENSORS_DEF = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDR = 2'd0;
    localparam logic [1:0] CFG_CONV_CMD  = 2'd1;
    localparam logic [1:0] CFG_READ_CMD  = 2'd2;

    localparam logic [7:0] BASE_ADDR_RST = 8'h90;
    localparam logic [7:0] CONV_CMD_RST  = 8'hEE;
    localparam logic [7:0] READ_CMD_RST  = 8'hAA;

    // Request and bus event codes
    localparam logic [2:0] FN_SCAN      = 3'd0;
    localparam logic [2:0] FN_READ      = 3'd1;
    localparam logic [2:0] FN_START     = 3'd2;
    localparam logic [2:0] FN_ADDR_ACK  = 3'd3;
    localparam logic [2:0] FN_BYTE_SENT = 3'd4;
    localparam logic [2:0] FN_BYTE_RX   = 3'd5;
    localparam logic [2:0] FN_NACK      = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SC_START = 4'd1,
        PH_SC_ADDR  = 4'd2,
        PH_SC_DATA  = 4'd3,
        PH_WR_START = 4'd4,
        PH_WR_ADDR  = 4'd5,
        PH_WR_DATA  = 4'd6,
        PH_RD_START = 4'd7,
        PH_RD_DATA  = 4'd8
    } phase_t;

    // Result word; the last member lands in the lowest bit
    typedef struct packed {
        logic signed [15:0] temperature;
        logic [7:0]         detected_map;
        logic               failed;
        logic               done_res;
        logic [7:0]         tx_byte;
        logic               tx_is_address;
        logic               tx_valid;
        logic               ack_off;
        logic               stop_req;
        logic               start_req;
    } result_t;

endpackage

// ===== hdl/i2c_thermometer_scan_and_read_core.sv =====
// ----------------------------------------------------------------------------
// i2c_thermometer_scan_and_read_core
// I2C master sequencer that scans and reads up to eight thermometers.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | request or bus event word
//  m_       | out       | bus actions and completion report, one per word
//  cfg_     | in        | base address, convert and read command bytes
//
//  The state machine decides on each input word in the cycle it is accepted,
//  and the result register holds the answer.
//  A new word is taken every cycle while the result register is empty or
//  is being drained; a stalled m_ side holds one result and blocks s_.
//  aresetn is synchronous, active low; it clears state and config to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_thermometer_scan_and_read_core #(
    parameter int NUM_SENSORS = tsr_pkg::NUM_SENSORS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] func, [5:3] sensor_id, [13:6] rx_byte, [15:14] zero
    input  logic [15:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] start_req, [1] stop_req, [2] ack_off, [3] tx_valid,
    // [4] tx_is_address, [12:5] tx_byte, [13] done_res, [14] failed,
    // [22:15] detected_map, [38:23] temperature, [39] zero
    output logic [39:0] m_tdata,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    // Configuration registers
    logic [7:0] base_addr_reg;
    logic [7:0] conv_cmd_reg;
    logic [7:0] read_cmd_reg;

    // Sequencer state
    tsr_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      target_reg, target_next;
    logic            rx_count_reg, rx_count_next;
    logic [7:0]      map_reg, map_next;
    logic [7:0]      high_byte_reg;

    // Result register
    logic            m_tvalid_reg;
    tsr_pkg::result_t res_reg, res_next;

    logic       s_accept;
    logic [2:0] func;
    logic [2:0] sensor_id;
    logic [7:0] rx_byte;
    logic       scan_more;
    logic       sensor_ok;
    logic       high_load;
    logic       read_go;

    // Unpack the input word
    assign func      = s_tdata[2:0];
    assign sensor_id = s_tdata[5:3];
    assign rx_byte   = s_tdata[13:6];

    // Take a word whenever the result register frees up this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Another index left to scan; sensor exists and answered the last scan
    assign scan_more = ({1'b0, target_reg} + 4'd1) < 4'(NUM_SENSORS);
    assign sensor_ok = ({1'b0, sensor_id} < 4'(NUM_SENSORS)) && map_reg[sensor_id];

    // First received byte of a read goes into the high byte store
    assign high_load = (phase_reg == tsr_pkg::PH_RD_DATA) && (func == tsr_pkg::FN_BYTE_RX)
                       && !rx_count_reg;

    // Idle read request that opens a bus transfer
    assign read_go = s_accept && (phase_reg == tsr_pkg::PH_IDLE)
                     && (phase_next == tsr_pkg::PH_WR_START);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        phase_next    = phase_reg;
        target_next   = target_reg;
        rx_count_next = rx_count_reg;
        map_next      = map_reg;
        case (phase_reg)
            tsr_pkg::PH_IDLE: begin
                if (func == tsr_pkg::FN_SCAN) begin
                    map_next      = 8'd0;
                    target_next   = 3'd0;
                    rx_count_next = 1'b0;
                    phase_next    = tsr_pkg::PH_SC_START;
                end else if (func == tsr_pkg::FN_READ && sensor_ok) begin
                    target_next   = sensor_id;
                    rx_count_next = 1'b0;
                    phase_next    = tsr_pkg::PH_WR_START;
                end
            end
            tsr_pkg::PH_SC_START: begin
                if (func == tsr_pkg::FN_START) begin
                    phase_next = tsr_pkg::PH_SC_ADDR;
                end
            end
            tsr_pkg::PH_SC_ADDR, tsr_pkg::PH_SC_DATA: begin
                if (phase_reg == tsr_pkg::PH_SC_ADDR && func == tsr_pkg::FN_ADDR_ACK) begin
                    phase_next = tsr_pkg::PH_SC_DATA;
                end else if (func == tsr_pkg::FN_NACK
                             || (phase_reg == tsr_pkg::PH_SC_DATA
                                 && func == tsr_pkg::FN_BYTE_SENT)) begin
                    // mark the index present only when the command went out
                    if (func == tsr_pkg::FN_BYTE_SENT) begin
                        map_next[target_reg] = 1'b1;
                    end
                    if (scan_more) begin
                        target_next   = target_reg + 3'd1;
                        rx_count_next = 1'b0;
                        phase_next    = tsr_pkg::PH_SC_START;
                    end else begin
                        phase_next = tsr_pkg::PH_IDLE;
                    end
                end
            end
            tsr_pkg::PH_WR_START: begin
                if (func == tsr_pkg::FN_START) begin
                    phase_next = tsr_pkg::PH_WR_ADDR;
                end
            end
            tsr_pkg::PH_WR_ADDR, tsr_pkg::PH_WR_DATA, tsr_pkg::PH_RD_START,
            tsr_pkg::PH_RD_DATA: begin
                if (func == tsr_pkg::FN_NACK && phase_reg != tsr_pkg::PH_RD_START) begin
                    phase_next = tsr_pkg::PH_IDLE;
                end else if (phase_reg == tsr_pkg::PH_WR_ADDR
                             && func == tsr_pkg::FN_ADDR_ACK) begin
                    phase_next = tsr_pkg::PH_WR_DATA;
                end else if (phase_reg == tsr_pkg::PH_WR_DATA
                             && func == tsr_pkg::FN_BYTE_SENT) begin
                    rx_count_next = 1'b0;
                    phase_next    = tsr_pkg::PH_RD_START;
                end else if (phase_reg == tsr_pkg::PH_RD_START
                             && func == tsr_pkg::FN_START) begin
                    phase_next = tsr_pkg::PH_RD_DATA;
                end else if (phase_reg == tsr_pkg::PH_RD_DATA
                             && func == tsr_pkg::FN_BYTE_RX) begin
                    if (!rx_count_reg) begin
                        rx_count_next = 1'b1;
                    end else begin
                        rx_count_next = 1'b0;
                        phase_next    = tsr_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                phase_next = tsr_pkg::PH_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    always_comb begin
        res_next = '0;
        case (phase_reg)
            tsr_pkg::PH_IDLE: begin
                if (func == tsr_pkg::FN_SCAN) begin
                    res_next.start_req = 1'b1;
                end else if (func == tsr_pkg::FN_READ) begin
                    if (sensor_ok) begin
                        res_next.start_req = 1'b1;
                    end else begin
                        // absent sensor: report failure, no bus traffic
                        res_next.done_res = 1'b1;
                        res_next.failed   = 1'b1;
                    end
                end
            end
            tsr_pkg::PH_SC_START, tsr_pkg::PH_WR_START: begin
                if (func == tsr_pkg::FN_START) begin
                    res_next.tx_valid      = 1'b1;
                    res_next.tx_is_address = 1'b1;
                    res_next.tx_byte       = base_addr_reg | {4'd0, target_reg, 1'b0};
                end
            end
            tsr_pkg::PH_SC_ADDR, tsr_pkg::PH_SC_DATA: begin
                if (phase_reg == tsr_pkg::PH_SC_ADDR && func == tsr_pkg::FN_ADDR_ACK) begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = conv_cmd_reg;
                end else if (func == tsr_pkg::FN_NACK
                             || (phase_reg == tsr_pkg::PH_SC_DATA
                                 && func == tsr_pkg::FN_BYTE_SENT)) begin
                    // stop this index, then start the next or finish the scan
                    res_next.stop_req  = 1'b1;
                    res_next.start_req = scan_more;
                    res_next.done_res  = !scan_more;
                end
            end
            tsr_pkg::PH_WR_ADDR, tsr_pkg::PH_WR_DATA, tsr_pkg::PH_RD_START,
            tsr_pkg::PH_RD_DATA: begin
                if (func == tsr_pkg::FN_NACK && phase_reg != tsr_pkg::PH_RD_START) begin
                    res_next.stop_req = 1'b1;
                    res_next.done_res = 1'b1;
                    res_next.failed   = 1'b1;
                end else if (phase_reg == tsr_pkg::PH_WR_ADDR
                             && func == tsr_pkg::FN_ADDR_ACK) begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_byte  = read_cmd_reg;
                end else if (phase_reg == tsr_pkg::PH_WR_DATA
                             && func == tsr_pkg::FN_BYTE_SENT) begin
                    res_next.start_req = 1'b1;
                end else if (phase_reg == tsr_pkg::PH_RD_START
                             && func == tsr_pkg::FN_START) begin
                    res_next.tx_valid      = 1'b1;
                    res_next.tx_is_address = 1'b1;
                    res_next.tx_byte       = base_addr_reg | {4'd0, target_reg, 1'b1};
                end else if (phase_reg == tsr_pkg::PH_RD_DATA
                             && func == tsr_pkg::FN_BYTE_RX) begin
                    if (!rx_count_reg) begin
                        // NACK the last byte and stop after it
                        res_next.stop_req = 1'b1;
                        res_next.ack_off  = 1'b1;
                    end else begin
                        res_next.done_res    = 1'b1;
                        res_next.temperature = {high_byte_reg, rx_byte};
                    end
                end
            end
            default: begin
                res_next = '0;
            end
        endcase
        res_next.detected_map = map_next;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= tsr_pkg::BASE_ADDR_RST;
            conv_cmd_reg  <= tsr_pkg::CONV_CMD_RST;
            read_cmd_reg  <= tsr_pkg::READ_CMD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tsr_pkg::CFG_BASE_ADDR: base_addr_reg <= cfg_wdata;
                tsr_pkg::CFG_CONV_CMD:  conv_cmd_reg  <= cfg_wdata;
                tsr_pkg::CFG_READ_CMD:  read_cmd_reg  <= cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= tsr_pkg::PH_IDLE;
            target_reg   <= 3'd0;
            rx_count_reg <= 1'b0;
            map_reg      <= 8'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg    <= phase_next;
                target_reg   <= target_next;
                rx_count_reg <= rx_count_next;
                map_reg      <= map_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
            if (high_load) begin
                high_byte_reg <= rx_byte;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "i2c_thermometer_scan_and_read_core_assert.svh"

    // A finished request always leaves the sequencer idle
    `TSR_ASSERT_NEXT(a_done_goes_idle, s_accept && res_next.done_res, phase_reg == tsr_pkg::PH_IDLE)
    // A failure is reported as done and carries a zero temperature
    `TSR_ASSERT_NOW(a_fail_zero_temp, m_tvalid && m_tdata[14], m_tdata[13] && !(|m_tdata[38:23]))
    // A read starts only for a sensor that answered the scan
    `TSR_ASSERT_NOW(a_read_present, read_go, map_reg[sensor_id])
    // No byte value without a byte to send
    `TSR_ASSERT_NOW(a_tx_byte_idle, m_tvalid && !m_tdata[3], m_tdata[12:5] == 8'd0)

endmodule
